FILE: design/gray_image_statistics_defines.svh
// assertion macros for the grayscale image statistics block
// needs a clock named clk and a synchronous reset named rst in the using module
`ifndef GRAY_IMAGE_STATISTICS_DEFINES_SVH
`define GRAY_IMAGE_STATISTICS_DEFINES_SVH

// same-cycle implication
`define GIS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gis_pkg.sv
// shared types and constants for the grayscale image statistics block
// no dependencies
package gis_pkg;

  localparam int PIXEL_W     = 8;
  localparam int CFG_W       = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int SUM_W       = 26;
  localparam int DEN_W       = 2 * CFG_W;
  localparam int CONTRAST_W  = 17;
  localparam int FRAC_W      = 16;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIV_LUM,
    ST_LOAD_CON,
    ST_DIV_CON,
    ST_OUTPUT
  } gis_state_t;

  typedef struct packed {
    logic accept;
    logic load_lum;
    logic load_con;
    logic step;
    logic out_load;
  } gis_cmd_t;

  typedef struct packed {
    logic pixel_last;
    logic out_busy;
  } gis_status_t;

endpackage

FILE: design/gis_ctrl.sv
// frame controller: pixel acceptance, divider sequencing and result hand-off
// depends on gis_pkg
module gis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gis_pkg::gis_status_t status,
  output gis_pkg::gis_cmd_t    cmd
);
  import gis_pkg::*;

  gis_state_t state, state_next;
  logic [STEP_CNT_W-1:0] step_cnt, step_cnt_next;
  logic step_end;

  assign step_end = (step_cnt == STEP_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.pixel_last) begin
          cmd.load_lum  = 1'b1;
          step_cnt_next = '0;
          state_next    = ST_DIV_LUM;
        end
      end
      ST_DIV_LUM: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_end) state_next = ST_LOAD_CON;
      end
      ST_LOAD_CON: begin
        cmd.load_con  = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_DIV_CON;
      end
      ST_DIV_CON: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_end) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

FILE: design/gis_datapath.sv
// accumulators, config registers, shared restoring divider and result registers
// depends on gis_pkg
module gis_datapath #(
  parameter int MAX_DIM = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [gis_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [gis_pkg::CFG_W-1:0]            cfg_data,
  input  logic [gis_pkg::PIXEL_W-1:0]          pixel,
  input  logic                                 last_pixel,
  input  gis_pkg::gis_cmd_t                    cmd,
  output gis_pkg::gis_status_t                 status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gis_pkg::PIXEL_W-1:0]          luminance,
  output logic [gis_pkg::PIXEL_W-1:0]          minimum,
  output logic [gis_pkg::PIXEL_W-1:0]          maximum,
  output logic [gis_pkg::CONTRAST_W-1:0]       contrast,
  output logic                                 contrast_undefined
);
  import gis_pkg::*;

  logic [CFG_W-1:0]   image_width, image_height;
  logic [SUM_W-1:0]   pixel_sum, sum_next;
  logic [SUM_W:0]     sum_wide;
  logic [PIXEL_W-1:0] running_min, running_max, min_next, max_next;
  logic               frame_started;

  logic [SUM_W-1:0]   quo;
  logic [DEN_W-1:0]   rem, den;
  logic [DEN_W:0]     rem_shift, diff;
  logic [DEN_W-1:0]   pixel_count;
  logic [PIXEL_W-1:0] lum_q;
  logic [PIXEL_W:0]   extreme_sum;
  logic [PIXEL_W-1:0] extreme_diff;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
    logic [CFG_W-1:0] r;
    r = d;
    if (d == '0) r = CFG_W'(1);
    else if (int'(d) > MAX_DIM) r = CFG_W'(MAX_DIM);
    return r;
  endfunction

  assign status.pixel_last = last_pixel;
  assign status.out_busy   = out_valid && !out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // running statistics
  assign sum_wide = {1'b0, pixel_sum} + (SUM_W + 1)'(pixel);
  assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  always_comb begin
    min_next = running_min;
    max_next = running_max;
    if (!frame_started) begin
      min_next = pixel;
      max_next = pixel;
    end else begin
      if (pixel < running_min) min_next = pixel;
      if (pixel > running_max) max_next = pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      pixel_sum     <= '0;
      running_min   <= {PIXEL_W{1'b1}};
      running_max   <= '0;
      frame_started <= 1'b0;
    end else if (cmd.accept) begin
      pixel_sum     <= sum_next;
      running_min   <= min_next;
      running_max   <= max_next;
      frame_started <= 1'b1;
    end
  end

  // shared divider, one quotient bit per cycle
  assign pixel_count  = eff_dim(image_width) * eff_dim(image_height);
  assign extreme_sum  = {1'b0, running_max} + {1'b0, running_min};
  assign extreme_diff = running_max - running_min;
  assign rem_shift    = {rem, quo[SUM_W-1]};
  assign diff         = rem_shift - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.load_lum) begin
      quo <= sum_next;
      rem <= '0;
      den <= pixel_count;
    end else if (cmd.load_con) begin
      quo   <= SUM_W'({extreme_diff, {FRAC_W{1'b0}}});
      rem   <= '0;
      den   <= DEN_W'(extreme_sum);
      lum_q <= (quo > SUM_W'({PIXEL_W{1'b1}})) ? {PIXEL_W{1'b1}} : quo[PIXEL_W-1:0];
    end else if (cmd.step) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DEN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      luminance          <= lum_q;
      minimum            <= running_min;
      maximum            <= running_max;
      contrast_undefined <= (extreme_sum == '0);
      contrast           <= (extreme_sum == '0) ? '0 : quo[CONTRAST_W-1:0];
    end
  end

endmodule

FILE: design/gray_image_statistics.sv
// Per-frame statistics of an 8-bit grayscale pixel stream: truncated mean over
// image_width*image_height, minimum, maximum and Michelson contrast in unsigned Q1.16.
// While a frame streams in, one pixel is taken every cycle. After the pixel
// flagged last, in_ready stays low: the mean and the contrast go
// one after the other through a single restoring divider that retires one
// quotient bit per cycle, with a load step between them and a final step that
// loads the result register. If the previous result has not been taken
// by then, in_ready stays low until it is. Pixels of the next frame are taken
// while a finished result waits in the output register.
// depends on gis_pkg, gis_ctrl, gis_datapath and gray_image_statistics_defines.svh
`include "gray_image_statistics_defines.svh"

module gray_image_statistics #(
  parameter int MAX_DIM = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gis_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gis_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gis_pkg::PIXEL_W-1:0]       pixel,
  input  logic                              last_pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gis_pkg::PIXEL_W-1:0]       luminance,
  output logic [gis_pkg::PIXEL_W-1:0]       minimum,
  output logic [gis_pkg::PIXEL_W-1:0]       maximum,
  output logic [gis_pkg::CONTRAST_W-1:0]    contrast,
  output logic                              contrast_undefined
);
  import gis_pkg::*;

  gis_cmd_t    cmd;
  gis_status_t status;

  gis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gis_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .pixel              (pixel),
    .last_pixel         (last_pixel),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .luminance          (luminance),
    .minimum            (minimum),
    .maximum            (maximum),
    .contrast           (contrast),
    .contrast_undefined (contrast_undefined)
  );

  `GIS_ASSERT_IMPLY(a_undef_zero, out_valid && contrast_undefined, contrast == '0, "undefined contrast not zero")
  `GIS_ASSERT_IMPLY(a_min_le_max, out_valid, minimum <= maximum, "minimum above maximum")
  `GIS_ASSERT_IMPLY(a_contrast_range, out_valid, contrast <= CONTRAST_W'(1 << FRAC_W), "contrast above one")
  `GIS_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && last_pixel, !in_ready, "request taken during division")

endmodule
